### src/alt_pkg.sv
`timescale 1ns / 1ps

package alt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int ADDR_W = 32;
	localparam int SIZE_W = 32;
	localparam int LINE_W = 16;
	localparam int SUM_W = 48;
	localparam int SLOT_W = 6;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NULL    = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	// One request walking down the chain of entry cells.
	typedef struct packed {
		logic              vld;
		logic              free_op;
		logic              null_addr;
		logic [ADDR_W-1:0] key;
		logic [SIZE_W-1:0] size;
		logic [LINE_W-1:0] line;
		logic [IDX_W-1:0]  pos;
		logic              hit;
		logic [IDX_W-1:0]  slot;
		logic [SIZE_W-1:0] fsize;
	} token_t;

endpackage

### src/alt_cell.sv
`timescale 1ns / 1ps

module alt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  alt_pkg::token_t tok_in,
	output alt_pkg::token_t tok_out
);

	logic [alt_pkg::ADDR_W-1:0] addr_q;
	logic [alt_pkg::SIZE_W-1:0] size_q;
	logic [alt_pkg::LINE_W-1:0] line_q;
	alt_pkg::token_t            tok_q;
	alt_pkg::token_t            tok_nxt;
	logic                       match;
	logic                       act;

	// An allocation takes the first free entry; a free takes the first entry holding the key.
	assign match = tok_in.free_op ? (addr_q == tok_in.key) : (addr_q == '0);
	assign act = tok_in.vld && !tok_in.hit && !tok_in.null_addr && match;

	always_comb begin
		tok_nxt = tok_in;
		tok_nxt.pos = tok_in.pos + alt_pkg::IDX_W'(1);
		if (act) begin
			tok_nxt.hit = 1'b1;
			tok_nxt.slot = tok_in.pos;
			tok_nxt.fsize = size_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (act) begin
				addr_q <= tok_in.free_op ? '0 : tok_in.key;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act && !tok_in.free_op) begin
			size_q <= tok_in.size;
			line_q <= tok_in.line;
		end
	end

	assign tok_out = tok_q;

endmodule

### src/allocation_leak_tracker_top.sv
`timescale 1ns / 1ps

// Channel   Handshake            Fields
// input     in_valid, in_stall   mode, address, alloc_size, source_line
// output    out_valid, out_stall status, slot_index, total_allocated, total_freed, leaked_bytes
//
// An item walks the chain of entry cells one cell per cycle, then its result passes through
// the status register into the output register.
// A new item is accepted once the previous result sits in the output register, so only
// one item is ever in the chain at a time.
// Reset frees every entry and clears both totals.
// A stalled result holds the output register and delays the next item's finish.

module allocation_leak_tracker_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [alt_pkg::ADDR_W-1:0]  address,
	input  logic [alt_pkg::SIZE_W-1:0]  alloc_size,
	input  logic [alt_pkg::LINE_W-1:0]  source_line,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [alt_pkg::SLOT_W-1:0]  slot_index,
	output logic [alt_pkg::SUM_W-1:0]   total_allocated,
	output logic [alt_pkg::SUM_W-1:0]   total_freed,
	output logic [alt_pkg::SUM_W-1:0]   leaked_bytes
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t                      state_q;
	alt_pkg::token_t             chain [0:alt_pkg::TABLE_ENTRIES];
	alt_pkg::token_t             fin;
	alt_pkg::status_t            fin_status;
	alt_pkg::status_t            status_q;
	logic [alt_pkg::SLOT_W-1:0]  slot_q;
	logic [alt_pkg::SUM_W-1:0]   sum_alloc_q;
	logic [alt_pkg::SUM_W-1:0]   sum_freed_q;
	logic                        out_valid_q;
	logic [1:0]                  status_out_q;
	logic [alt_pkg::SLOT_W-1:0]  slot_out_q;
	logic [alt_pkg::SUM_W-1:0]   tot_alloc_q;
	logic [alt_pkg::SUM_W-1:0]   tot_freed_q;
	logic [alt_pkg::SUM_W-1:0]   leaked_q;
	logic                        accept;
	logic                        load;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		chain[0] = '0;
		chain[0].vld = accept;
		chain[0].free_op = mode;
		chain[0].null_addr = (address == '0);
		chain[0].key = address;
		chain[0].size = alloc_size;
		chain[0].line = source_line;
	end

	for (genvar i = 0; i < alt_pkg::TABLE_ENTRIES; i++) begin : g_cell
		alt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (chain[i]),
			.tok_out(chain[i+1])
		);
	end

	assign fin = chain[alt_pkg::TABLE_ENTRIES];

	always_comb begin
		if (fin.null_addr) begin
			fin_status = alt_pkg::ST_NULL;
		end else if (!fin.hit) begin
			fin_status = fin.free_op ? alt_pkg::ST_MISSING : alt_pkg::ST_FULL;
		end else begin
			fin_status = alt_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sum_alloc_q <= '0;
			sum_freed_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (fin.vld) begin
						state_q <= S_OUT;
						if (fin_status == alt_pkg::ST_OK) begin
							if (fin.free_op) begin
								sum_freed_q <= sum_freed_q + alt_pkg::SUM_W'(fin.fsize);
							end else begin
								sum_alloc_q <= sum_alloc_q + alt_pkg::SUM_W'(fin.size);
							end
						end
					end
				end
				S_OUT: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RUN && fin.vld) begin
			status_q <= fin_status;
			slot_q <= (fin_status == alt_pkg::ST_OK) ? alt_pkg::SLOT_W'(fin.slot) : '0;
		end
		if (load) begin
			status_out_q <= status_q;
			slot_out_q <= slot_q;
			tot_alloc_q <= sum_alloc_q;
			tot_freed_q <= sum_freed_q;
			leaked_q <= sum_alloc_q - sum_freed_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_out_q;
	assign slot_index = slot_out_q;
	assign total_allocated = tot_alloc_q;
	assign total_freed = tot_freed_q;
	assign leaked_bytes = leaked_q;

endmodule
